// ===== rtl/dxt1_block_encoder_defines.svh =====
// Assertion macros shared by the block compressor RTL.
`ifndef DXT1_BLOCK_ENCODER_DEFINES_SVH
`define DXT1_BLOCK_ENCODER_DEFINES_SVH

// Same-cycle implication check.
`define DBE_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbe: same-cycle check failed");

// Next-cycle implication check.
`define DBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbe: next-cycle check failed");

`endif

// ===== rtl/dbe_pkg.sv =====
// Shared types and constants of the 4x4 block compressor.
package dbe_pkg;

    localparam int NumPixels  = 16;
    localparam int PixelIdxW  = $clog2(NumPixels);
    localparam int NumEntries = 4;

    localparam logic [5:0]  Max5Bit     = 6'd31;
    localparam logic [5:0]  Max6Bit     = 6'd63;
    localparam logic [6:0]  RoundBias   = 7'd127;
    localparam logic [2:0]  WeightNear  = 3'd5;
    localparam logic [2:0]  WeightFar   = 3'd3;
    localparam logic [15:0] EndpointTop = 16'hFFFF;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } t_in_item;

    typedef struct packed {
        logic [15:0] endpoint_high;
        logic [15:0] endpoint_low;
        logic [31:0] index_bits;
    } t_out_item;

    typedef t_in_item [NumEntries-1:0] t_palette;

    typedef struct packed {
        logic calc;
        logic adjust;
        logic palette;
    } t_ep_ctrl;

endpackage

// ===== rtl/dbe_pixel_cell.sv =====
// One cell of the pixel chain: holds a pixel and passes it on when shifted.
module dbe_pixel_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  dbe_pkg::t_in_item i_pixel,
    output dbe_pkg::t_in_item o_pixel
);
    import dbe_pkg::*;

    t_in_item r_pixel;

    // Advance the chain by one place
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pixel <= i_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

// ===== rtl/dbe_endpoint.sv =====
// Endpoint quantization, ordering and four-entry palette build.
module dbe_endpoint (
    input  logic              i_clk,
    input  dbe_pkg::t_ep_ctrl  i_ctrl,
    input  dbe_pkg::t_in_item  i_least,
    input  dbe_pkg::t_in_item  i_most,
    output logic [15:0]       o_e0,
    output logic [15:0]       o_e1,
    output dbe_pkg::t_palette  o_palette
);
    import dbe_pkg::*;

    // (v*n + 127) / 255, division by 255 through (x + 1 + (x >> 8)) >> 8
    function automatic logic [5:0] f_quant(input logic [7:0] v, input logic [5:0] n);
        logic [13:0] x;
        logic [14:0] s;
        x = 14'(v) * 14'(n) + 14'(RoundBias);
        s = 15'(x) + 15'd1 + 15'(x >> 8);
        return 6'(s >> 8);
    endfunction

    function automatic t_in_item f_expand(input logic [15:0] c);
        t_in_item p;
        p.pixel_red   = {c[15:11], c[15:13]};
        p.pixel_green = {c[10:5], c[10:9]};
        p.pixel_blue  = {c[4:0], c[4:2]};
        return p;
    endfunction

    // (5*a + 3*b) >> 3
    function automatic logic [7:0] f_blend(input logic [7:0] a, input logic [7:0] b);
        logic [10:0] s;
        s = 11'(a) * 11'(WeightNear) + 11'(b) * 11'(WeightFar);
        return s[10:3];
    endfunction

    function automatic t_in_item f_mix(input t_in_item a, input t_in_item b);
        t_in_item p;
        p.pixel_red   = f_blend(a.pixel_red, b.pixel_red);
        p.pixel_green = f_blend(a.pixel_green, b.pixel_green);
        p.pixel_blue  = f_blend(a.pixel_blue, b.pixel_blue);
        return p;
    endfunction

    logic [15:0] r_raw0;
    logic [15:0] r_raw1;
    logic [15:0] r_e0;
    logic [15:0] r_e1;
    t_palette    r_palette;

    logic [15:0] w_raw0;
    logic [15:0] w_raw1;
    logic [15:0] n_e0;
    logic [15:0] n_e1;
    t_in_item    w_c0;
    t_in_item    w_c1;
    logic [5:0]  w_q_r0, w_q_b0, w_q_r1, w_q_b1;

    // Round the max corner and the min corner to RGB565
    always_comb begin
        w_q_r0 = f_quant(i_most.pixel_red, Max5Bit);
        w_q_b0 = f_quant(i_most.pixel_blue, Max5Bit);
        w_q_r1 = f_quant(i_least.pixel_red, Max5Bit);
        w_q_b1 = f_quant(i_least.pixel_blue, Max5Bit);
        w_raw0 = {w_q_r0[4:0], f_quant(i_most.pixel_green, Max6Bit), w_q_b0[4:0]};
        w_raw1 = {w_q_r1[4:0], f_quant(i_least.pixel_green, Max6Bit), w_q_b1[4:0]};
    end

    // Order the endpoints and bump them apart when equal
    always_comb begin
        if (r_raw0 < r_raw1) begin
            n_e0 = r_raw1;
            n_e1 = r_raw0;
        end else begin
            n_e0 = r_raw0;
            n_e1 = r_raw1;
        end
        if (n_e0 == n_e1) begin
            if (n_e0 == EndpointTop) begin
                n_e1 = n_e1 - 16'd1;
            end else begin
                n_e0 = n_e0 + 16'd1;
            end
        end
    end

    assign w_c0 = f_expand(r_e0);
    assign w_c1 = f_expand(r_e1);

    // Step through quantize, order, palette
    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc) begin
            r_raw0 <= w_raw0;
            r_raw1 <= w_raw1;
        end
        if (i_ctrl.adjust) begin
            r_e0 <= n_e0;
            r_e1 <= n_e1;
        end
        if (i_ctrl.palette) begin
            r_palette[0] <= w_c0;
            r_palette[1] <= w_c1;
            r_palette[2] <= f_mix(w_c0, w_c1);
            r_palette[3] <= f_mix(w_c1, w_c0);
        end
    end

    assign o_e0      = r_e0;
    assign o_e1      = r_e1;
    assign o_palette = r_palette;

endmodule

// ===== rtl/dbe_classifier.sv =====
// Two-stage nearest palette entry search for one pixel per cycle.
module dbe_classifier (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dbe_pkg::t_in_item  i_pixel,
    input  dbe_pkg::t_palette  i_palette,
    output logic              o_valid,
    output logic [1:0]        o_index
);
    import dbe_pkg::*;

    function automatic logic [15:0] f_sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    logic        r_valid_a;
    logic [15:0] r_sq_r [NumEntries];
    logic [15:0] r_sq_g [NumEntries];
    logic [15:0] r_sq_b [NumEntries];
    logic        r_valid_b;
    logic [1:0]  r_index;

    logic [17:0] w_err [NumEntries];
    logic [17:0] w_err01;
    logic [17:0] w_err23;
    logic [1:0]  w_pick01;
    logic [1:0]  w_pick23;
    logic [1:0]  n_index;

    // Stage A: squared channel errors against every entry
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NumEntries; k++) begin
            r_sq_r[k] <= f_sq_diff(i_pixel.pixel_red, i_palette[k].pixel_red);
            r_sq_g[k] <= f_sq_diff(i_pixel.pixel_green, i_palette[k].pixel_green);
            r_sq_b[k] <= f_sq_diff(i_pixel.pixel_blue, i_palette[k].pixel_blue);
        end
    end

    // Stage B: sum and pick the least error, lower index on a tie
    always_comb begin
        for (int k = 0; k < NumEntries; k++) begin
            w_err[k] = 18'(r_sq_r[k]) + 18'(r_sq_g[k]) + 18'(r_sq_b[k]);
        end
        if (w_err[1] < w_err[0]) begin
            w_pick01 = 2'd1;
            w_err01  = w_err[1];
        end else begin
            w_pick01 = 2'd0;
            w_err01  = w_err[0];
        end
        if (w_err[3] < w_err[2]) begin
            w_pick23 = 2'd3;
            w_err23  = w_err[3];
        end else begin
            w_pick23 = 2'd2;
            w_err23  = w_err[2];
        end
        n_index = (w_err23 < w_err01) ? w_pick23 : w_pick01;
    end

    always_ff @(posedge i_clk) begin
        r_index <= n_index;
    end

    // Track valid through both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_index = r_index;

endmodule

// ===== rtl/dxt1_block_encoder.sv =====
// Per block: load the 16 pixels, quantize, order and build the palette, feed each pixel
// of the chain through the two-stage classifier, drain and hand off; one pixel per cycle
// while loading. No pixels are taken between the 16th pixel and the result hand-off.
// Reset (synchronous, active low) empties the output, clears the counts and resets the bounds.
`include "dxt1_block_encoder_defines.svh"

module dxt1_block_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dbe_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dbe_pkg::t_out_item o_out_data
);
    import dbe_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CALC,
        S_ADJUST,
        S_PALETTE,
        S_CLASSIFY,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [PixelIdxW-1:0] r_count;
    logic [PixelIdxW-1:0] r_idx_count;
    logic                 r_out_valid;
    t_out_item            r_out_data;
    t_in_item             r_least;
    t_in_item             r_most;
    logic [1:0]           r_idx_slot [NumPixels];

    t_in_item    w_cell_in  [NumPixels];
    t_in_item    w_cell_out [NumPixels];
    logic        w_shift;
    logic        w_accept;
    logic        w_out_free;
    logic        w_block_end;
    logic        w_feed;
    t_ep_ctrl    w_ep_ctrl;
    logic [15:0] w_e0;
    logic [15:0] w_e1;
    t_palette    w_palette;
    logic        w_cls_valid;
    logic [1:0]  w_cls_index;
    logic [31:0] w_bits;
    logic        w_ep_ordered;
    logic        w_cls_window;
    logic        w_bounds_ok;

    assign o_in_ready  = (r_state == S_LOAD);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_block_end = (r_state == S_DONE) && w_out_free;
    assign w_feed      = (r_state == S_CLASSIFY);
    assign w_shift     = w_accept || w_feed;

    // Pixel chain: load from the input, recirculate while classifying
    always_comb begin
        w_cell_in[0] = w_feed ? w_cell_out[NumPixels-1] : i_in_data;
        for (int k = 1; k < NumPixels; k++) begin
            w_cell_in[k] = w_cell_out[k-1];
        end
    end

    for (genvar g = 0; g < NumPixels; g++) begin : g_cell
        dbe_pixel_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_pixel (w_cell_in[g]),
            .o_pixel (w_cell_out[g])
        );
    end

    assign w_ep_ctrl.calc    = (r_state == S_CALC);
    assign w_ep_ctrl.adjust  = (r_state == S_ADJUST);
    assign w_ep_ctrl.palette = (r_state == S_PALETTE);

    dbe_endpoint u_endpoint (
        .i_clk     (i_clk),
        .i_ctrl    (w_ep_ctrl),
        .i_least   (r_least),
        .i_most    (r_most),
        .o_e0      (w_e0),
        .o_e1      (w_e1),
        .o_palette (w_palette)
    );

    dbe_classifier u_classifier (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_feed),
        .i_pixel   (w_cell_out[NumPixels-1]),
        .i_palette (w_palette),
        .o_valid   (w_cls_valid),
        .o_index   (w_cls_index)
    );

    // Track per-channel bounds of the block; restore them at block end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_block_end) begin
            r_least <= '1;
            r_most  <= '0;
        end else if (w_accept) begin
            if (i_in_data.pixel_red < r_least.pixel_red) begin
                r_least.pixel_red <= i_in_data.pixel_red;
            end
            if (i_in_data.pixel_red > r_most.pixel_red) begin
                r_most.pixel_red <= i_in_data.pixel_red;
            end
            if (i_in_data.pixel_green < r_least.pixel_green) begin
                r_least.pixel_green <= i_in_data.pixel_green;
            end
            if (i_in_data.pixel_green > r_most.pixel_green) begin
                r_most.pixel_green <= i_in_data.pixel_green;
            end
            if (i_in_data.pixel_blue < r_least.pixel_blue) begin
                r_least.pixel_blue <= i_in_data.pixel_blue;
            end
            if (i_in_data.pixel_blue > r_most.pixel_blue) begin
                r_most.pixel_blue <= i_in_data.pixel_blue;
            end
        end
    end

    // Shift each new index into the slot line; slot 15-p ends up holding pixel p
    always_ff @(posedge i_clk) begin
        if (w_cls_valid) begin
            r_idx_slot[0] <= w_cls_index;
            for (int k = 1; k < NumPixels; k++) begin
                r_idx_slot[k] <= r_idx_slot[k-1];
            end
        end
    end

    // Place pixel p at row byte 3-row, column pair col
    always_comb begin
        w_bits = '0;
        for (int p = 0; p < NumPixels; p++) begin
            w_bits[(3 - (p >> 2)) * 8 + (p & 3) * 2 +: 2] = r_idx_slot[NumPixels-1-p];
        end
    end

    // Sequencer with the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_idx_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid on hand-off, drop it once the transaction is taken
            if (w_block_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        r_count <= r_count + PixelIdxW'(1);
                        if (r_count == PixelIdxW'(NumPixels - 1)) begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    r_state <= S_ADJUST;
                end
                S_ADJUST: begin
                    r_state <= S_PALETTE;
                end
                S_PALETTE: begin
                    r_state <= S_CLASSIFY;
                end
                S_CLASSIFY: begin
                    r_count <= r_count + PixelIdxW'(1);
                    if (r_count == PixelIdxW'(NumPixels - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_cls_valid && r_idx_count == PixelIdxW'(NumPixels - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_data.endpoint_high <= w_e0;
                        r_out_data.endpoint_low  <= w_e1;
                        r_out_data.index_bits    <= w_bits;
                        r_count                  <= '0;
                        r_state                  <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
            if (w_cls_valid) begin
                r_idx_count <= r_idx_count + PixelIdxW'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Conditions checked by the assertions below
    assign w_ep_ordered = o_out_data.endpoint_high > o_out_data.endpoint_low;
    assign w_cls_window = (r_state == S_CLASSIFY) || (r_state == S_DRAIN);
    assign w_bounds_ok  = (r_least.pixel_red <= r_most.pixel_red) &&
                          (r_least.pixel_green <= r_most.pixel_green) &&
                          (r_least.pixel_blue <= r_most.pixel_blue);

    `DBE_ASSERT_HOLDS(a_endpoint_order, i_clk, i_rst_n, o_out_valid, w_ep_ordered)
    `DBE_ASSERT_HOLDS(a_cls_window, i_clk, i_rst_n, w_cls_valid, w_cls_window)
    `DBE_ASSERT_HOLDS(a_bounds_order, i_clk, i_rst_n, r_state == S_CALC, w_bounds_ok)
    `DBE_ASSERT_NEXT(a_handoff, i_clk, i_rst_n, w_block_end, o_out_valid && o_in_ready)

endmodule

// ===== tb/dxt1_block_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the 4x4 block compressor, with its own block-code predictor.
module dxt1_block_encoder_tb;
    import dbe_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int StallCycles = 400;
    localparam int DrainCycles = 60;
    localparam int IdlePercent = 27;
    localparam int ReportLimit = 10;

    typedef enum int {
        BlkNoise,
        BlkNarrow,
        BlkTwoTone,
        BlkFlat
    } t_block_kind;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      pix_valid  = 1'b0;
    t_in_item  pix_data   = '0;
    logic      pix_ready;
    logic      code_valid;
    logic      code_ready = 1'b0;
    t_out_item code_data;

    logic no_idle      = 1'b0;
    logic stall_toggle = 1'b0;
    logic stall_seen   = 1'b0;
    int   stall_left   = 0;
    int   cycles       = 0;
    int   mismatches   = 0;

    // Predicted block codes, oldest first
    t_out_item expected_codes[$];

    // Predictor copy of the block being loaded
    t_in_item blk_px[NumPixels];
    int       blk_fill = 0;
    t_in_item blk_lo   = '1;
    t_in_item blk_hi   = '0;

    dxt1_block_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (pix_valid),
        .o_in_ready  (pix_ready),
        .i_in_data   (pix_data),
        .o_out_valid (code_valid),
        .i_out_ready (code_ready),
        .o_out_data  (code_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Round an RGB888 colour to RGB565
    function automatic logic [15:0] round_565(t_in_item c);
        int unsigned r5, g6, b5;
        r5 = (c.pixel_red * 31 + 127) / 255;
        g6 = (c.pixel_green * 63 + 127) / 255;
        b5 = (c.pixel_blue * 31 + 127) / 255;
        return {r5[4:0], g6[5:0], b5[4:0]};
    endfunction

    // Widen RGB565 back to RGB888 by replicating the top bits
    function automatic t_in_item expand_565(logic [15:0] c);
        t_in_item px;
        px.pixel_red   = {c[15:11], c[15:13]};
        px.pixel_green = {c[10:5], c[10:9]};
        px.pixel_blue  = {c[4:0], c[4:2]};
        return px;
    endfunction

    // Weighted mix in eighths: wa/8 of a plus the rest of b, truncated
    function automatic t_in_item blend(t_in_item a, t_in_item b, int unsigned wa);
        int unsigned wb;
        t_in_item    m;
        wb            = 8 - wa;
        m.pixel_red   = 8'((wa * a.pixel_red + wb * b.pixel_red) >> 3);
        m.pixel_green = 8'((wa * a.pixel_green + wb * b.pixel_green) >> 3);
        m.pixel_blue  = 8'((wa * a.pixel_blue + wb * b.pixel_blue) >> 3);
        return m;
    endfunction

    function automatic int unsigned colour_error(t_in_item a, t_in_item b);
        int ar, br, dr, dg, db;
        ar = int'(a.pixel_red);   br = int'(b.pixel_red);   dr = ar - br;
        ar = int'(a.pixel_green); br = int'(b.pixel_green); dg = ar - br;
        ar = int'(a.pixel_blue);  br = int'(b.pixel_blue);  db = ar - br;
        return dr * dr + dg * dg + db * db;
    endfunction

    // Endpoints, palette and per-pixel indexes of the loaded block
    function automatic t_out_item encode_block();
        logic [15:0] ep_hi, ep_lo, ep_tmp;
        t_palette    pal;
        int unsigned err, least_err;
        logic [1:0]  best;
        t_out_item   code;
        ep_hi = round_565(blk_hi);
        ep_lo = round_565(blk_lo);
        if (ep_hi < ep_lo) begin
            ep_tmp = ep_hi;
            ep_hi  = ep_lo;
            ep_lo  = ep_tmp;
        end
        // Force the endpoints apart; the top code can only move down
        if (ep_hi == ep_lo) begin
            if (ep_hi != EndpointTop) ep_hi = ep_hi + 16'd1;
            else ep_lo = ep_lo - 16'd1;
        end
        pal[0] = expand_565(ep_hi);
        pal[1] = expand_565(ep_lo);
        pal[2] = blend(pal[0], pal[1], 5);
        pal[3] = blend(pal[0], pal[1], 3);
        code.endpoint_high = ep_hi;
        code.endpoint_low  = ep_lo;
        code.index_bits    = '0;
        // Least error wins; strict compare keeps the lower index on a tie
        for (int p = 0; p < NumPixels; p++) begin
            best      = 2'd0;
            least_err = colour_error(blk_px[p], pal[0]);
            for (int k = 1; k < NumEntries; k++) begin
                err = colour_error(blk_px[p], pal[k]);
                if (err < least_err) begin
                    least_err = err;
                    best      = 2'(k);
                end
            end
            code.index_bits[(3 - p / 4) * 8 + (p % 4) * 2 +: 2] = best;
        end
        return code;
    endfunction

    // Track one accepted pixel; on the 16th, predict the block code
    function automatic void record_pixel(t_in_item px);
        blk_px[blk_fill] = px;
        if (px.pixel_red < blk_lo.pixel_red)     blk_lo.pixel_red   = px.pixel_red;
        if (px.pixel_red > blk_hi.pixel_red)     blk_hi.pixel_red   = px.pixel_red;
        if (px.pixel_green < blk_lo.pixel_green) blk_lo.pixel_green = px.pixel_green;
        if (px.pixel_green > blk_hi.pixel_green) blk_hi.pixel_green = px.pixel_green;
        if (px.pixel_blue < blk_lo.pixel_blue)   blk_lo.pixel_blue  = px.pixel_blue;
        if (px.pixel_blue > blk_hi.pixel_blue)   blk_hi.pixel_blue  = px.pixel_blue;
        if (blk_fill == NumPixels - 1) begin
            expected_codes.push_back(encode_block());
            blk_fill = 0;
            blk_lo   = '1;
            blk_hi   = '0;
        end else begin
            blk_fill++;
        end
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] v, int unsigned d);
        return (v + d > 255) ? 8'd255 : 8'(v + d);
    endfunction

    function automatic t_block_kind pick_kind();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return BlkNoise;
        if (roll < 65) return BlkNarrow;
        if (roll < 90) return BlkTwoTone;
        return BlkFlat;
    endfunction

    // Offer one pixel, with random idle cycles ahead of it, and hold until taken
    task automatic send_pixel(t_in_item px);
        while (!no_idle && $urandom_range(99) < IdlePercent) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
        record_pixel(px);
    endtask

    task automatic send_block(t_block_kind kind);
        t_in_item    base, other, px;
        int unsigned spread;
        base   = 24'($urandom);
        other  = 24'($urandom);
        spread = $urandom_range(7);
        for (int p = 0; p < NumPixels; p++) begin
            case (kind)
                BlkNoise: begin
                    px = 24'($urandom);
                end
                BlkNarrow: begin
                    px.pixel_red   = nudge(base.pixel_red, $urandom_range(spread));
                    px.pixel_green = nudge(base.pixel_green, $urandom_range(spread));
                    px.pixel_blue  = nudge(base.pixel_blue, $urandom_range(spread));
                end
                BlkTwoTone: begin
                    // Midway mixes tend to land between palette entries
                    case ($urandom_range(3))
                        0:       px = base;
                        1:       px = other;
                        2:       px = blend(base, other, 4);
                        default: px = blend(base, other, 2);
                    endcase
                end
                default: begin
                    px = base;
                end
            endcase
            send_pixel(px);
        end
    endtask

    task automatic drain_expected();
        while (expected_codes.size() != 0) @(posedge clk);
    endtask

    // Uniform white and black blocks: equal endpoints at both ends of the code range
    task automatic test_flat_extremes();
        for (int p = 0; p < NumPixels; p++) send_pixel('1);
        for (int p = 0; p < NumPixels; p++) send_pixel('0);
    endtask

    task automatic test_random_blocks(int n);
        for (int b = 0; b < n; b++) send_block(pick_kind());
    endtask

    // Hold the result side off while pixels keep coming, so the input stalls
    task automatic test_output_backpressure();
        stall_toggle <= ~stall_toggle;
        for (int b = 0; b < 3; b++) send_block(pick_kind());
    endtask

    // Stop sending until every result is out, once mid-block
    task automatic test_pause_for_drain();
        send_block(pick_kind());
        for (int p = 0; p < 7; p++) send_pixel(24'($urandom));
        pix_valid <= 1'b0;
        @(posedge clk);
        drain_expected();
        for (int p = 7; p < NumPixels; p++) send_pixel(24'($urandom));
    endtask

    task automatic test_steady_stream();
        no_idle <= 1'b1;
        for (int b = 0; b < 4; b++) send_block(pick_kind());
        no_idle <= 1'b0;
    endtask

    // Drive result-side ready: long hold-off on request, else random stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            code_ready <= 1'b0;
        end else if (stall_toggle != stall_seen) begin
            stall_seen <= stall_toggle;
            stall_left <= StallCycles;
            code_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            code_ready <= 1'b0;
        end else if (no_idle) begin
            code_ready <= 1'b1;
        end else begin
            code_ready <= ($urandom_range(99) >= IdlePercent);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk) begin : check_codes
        t_out_item want;
        if (rst_n && code_valid && code_ready) begin
            if (expected_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("unexpected code: %h %h %h", code_data.endpoint_high,
                             code_data.endpoint_low, code_data.index_bits);
            end else begin
                want = expected_codes.pop_front();
                if (want.endpoint_high !== code_data.endpoint_high ||
                    want.endpoint_low !== code_data.endpoint_low ||
                    want.index_bits !== code_data.index_bits) begin
                    mismatches++;
                    if (mismatches <= ReportLimit)
                        $display("code mismatch: want %h %h %h, got %h %h %h",
                                 want.endpoint_high, want.endpoint_low, want.index_bits,
                                 code_data.endpoint_high, code_data.endpoint_low,
                                 code_data.index_bits);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("FAIL dxt1_block_encoder");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_flat_extremes();
        test_random_blocks(16);
        test_output_backpressure();
        test_pause_for_drain();
        test_steady_stream();
        pix_valid <= 1'b0;
        drain_expected();
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0) $display("PASS dxt1_block_encoder");
        else $display("FAIL dxt1_block_encoder");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dbe_pkg.sv
rtl/dbe_pixel_cell.sv
rtl/dbe_endpoint.sv
rtl/dbe_classifier.sv
rtl/dxt1_block_encoder.sv
tb/dxt1_block_encoder_tb.sv
